/* rtl/sm4ofb_pkg.sv */
// ----------------------------------------------------------------------------
// sm4ofb_pkg
// Shared types, constants and the SM4 round mixer for the OFB cipher block.
// ----------------------------------------------------------------------------
package sm4ofb_pkg;

  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned RND_W       = $clog2(ROUND_COUNT);
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned CNT_W       = 5;

  typedef enum logic [1:0] {
    OP_LOAD_KEY = 2'd0,
    OP_LOAD_FB  = 2'd1,
    OP_DATA     = 2'd2
  } op_e;

  typedef logic [31:0] word_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Byte-wise S-box followed by the linear transform L.
  function automatic word_t mix_t(word_t a);
    word_t b;
    b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
             ^ {b[7:0], b[31:8]};
  endfunction

endpackage

/* rtl/sm4ofb_in_if.sv */
// ----------------------------------------------------------------------------
// sm4ofb_in_if
// Request channel: operation code, round-key load fields and a data block.
// ----------------------------------------------------------------------------
interface sm4ofb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [4:0]  key_index;
  logic [31:0] round_key;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  logic [4:0]  valid_bytes;

  modport source (output valid, operation, key_index, round_key, block_hi, block_lo,
                  valid_bytes, input ready);
  modport sink   (input valid, operation, key_index, round_key, block_hi, block_lo,
                  valid_bytes, output ready);
endinterface

/* rtl/sm4ofb_out_if.sv */
// ----------------------------------------------------------------------------
// sm4ofb_out_if
// Result channel: masked output block and its byte count.
// ----------------------------------------------------------------------------
interface sm4ofb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_hi;
  logic [63:0] out_lo;
  logic [4:0]  out_bytes;

  modport source (output valid, out_hi, out_lo, out_bytes, input ready);
  modport sink   (input valid, out_hi, out_lo, out_bytes, output ready);
endinterface

/* rtl/sm4ofb_ram.sv */
// ----------------------------------------------------------------------------
// sm4ofb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sm4ofb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sm4_ofb_stream_cipher_top.sv */
// ----------------------------------------------------------------------------
// sm4_ofb_stream_cipher_top
// SM4 output-feedback stream cipher, one round per cycle on a shared mixer.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                              | accept
//  req_i   | in  | operation key_index round_key block_hi/lo valid_bytes | valid&ready
//  rsp_o   | out | out_hi out_lo out_bytes                             | valid&ready
//
//  A load is done when it is accepted. A data block is accepted in idle, runs
//  its rounds in the round state on the single round mixer and forms its
//  result in the output state; the next request is accepted only once the
//  state is back in idle. The round-key store has a registered read port, so
//  the key for round r+1 is fetched during round r. Reset clears the feedback
//  value and control; the key store is undefined until loaded. A stalled
//  result sits in the output register; a new data block waits in the output
//  state only if that result is still not taken when its own rounds finish.
// ----------------------------------------------------------------------------
module sm4_ofb_stream_cipher_top (
  input  logic clk_i,
  input  logic rst_ni,
  sm4ofb_in_if.sink    req_i,
  sm4ofb_out_if.source rsp_o
);
  import sm4ofb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_OUT} state_e;

  state_e             state_q;
  logic [RND_W-1:0]   round_q;
  word_t              x_q [4];
  logic [63:0]        fb_hi_q, fb_lo_q;
  logic [63:0]        dat_hi_q, dat_lo_q;
  logic [CNT_W-1:0]   nbytes_q;
  logic               out_valid_q;
  logic [63:0]        out_hi_q, out_lo_q;
  logic [CNT_W-1:0]   out_bytes_q;

  logic               req_fire;
  logic               key_we;
  logic [RND_W-1:0]   key_raddr;
  word_t              round_key;
  word_t              round_new;
  logic [CNT_W-1:0]   nbytes_sat;
  logic [127:0]       byte_mask;
  logic [127:0]       keystream;
  logic               out_free;
  logic               out_load;

  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUND_COUNT - 1);

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign key_we      = req_fire && (op_e'(req_i.operation) == OP_LOAD_KEY);

  // Prefetch the next round's key; idle keeps round zero's key ready.
  assign key_raddr = (state_q == ST_ROUND) ? round_q + RND_W'(1) : '0;

  sm4ofb_ram #(
    .WIDTH (32),
    .DEPTH (ROUND_COUNT)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (req_i.key_index),
    .wdata_i (req_i.round_key),
    .raddr_i (key_raddr),
    .rdata_o (round_key)
  );

  assign round_new = x_q[0] ^ mix_t(x_q[1] ^ x_q[2] ^ x_q[3] ^ round_key);

  assign nbytes_sat = (req_i.valid_bytes > CNT_W'(BLOCK_BYTES)) ? CNT_W'(BLOCK_BYTES)
                                                                : req_i.valid_bytes;

  // Reversed-word output of the last round state.
  assign keystream = {x_q[3], x_q[2], x_q[1], x_q[0]};

  always_comb begin
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      byte_mask[127-8*i -: 8] = (CNT_W'(i) < nbytes_q) ? 8'hff : 8'h00;
    end
  end

  assign out_free = !out_valid_q || rsp_o.ready;
  assign out_load = (state_q == ST_OUT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      round_q     <= '0;
      out_valid_q <= 1'b0;
      fb_hi_q     <= '0;
      fb_lo_q     <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            case (op_e'(req_i.operation))
              OP_LOAD_FB: begin
                fb_hi_q <= req_i.block_hi;
                fb_lo_q <= req_i.block_lo;
              end
              OP_DATA: begin
                // Drop a block with no bytes: no result, feedback held.
                if (req_i.valid_bytes != '0) begin
                  x_q[0]   <= fb_hi_q[63:32];
                  x_q[1]   <= fb_hi_q[31:0];
                  x_q[2]   <= fb_lo_q[63:32];
                  x_q[3]   <= fb_lo_q[31:0];
                  dat_hi_q <= req_i.block_hi;
                  dat_lo_q <= req_i.block_lo;
                  nbytes_q <= nbytes_sat;
                  round_q  <= '0;
                  state_q  <= ST_ROUND;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ROUND: begin
          x_q[0] <= x_q[1];
          x_q[1] <= x_q[2];
          x_q[2] <= x_q[3];
          x_q[3] <= round_new;
          if (round_q == LAST_ROUND) begin
            state_q <= ST_OUT;
          end else begin
            round_q <= round_q + RND_W'(1);
          end
        end
        ST_OUT: begin
          // Hold until the output register is free.
          if (out_free) begin
            out_hi_q    <= (dat_hi_q ^ keystream[127:64]) & byte_mask[127:64];
            out_lo_q    <= (dat_lo_q ^ keystream[63:0]) & byte_mask[63:0];
            out_bytes_q <= nbytes_q;
            fb_hi_q     <= keystream[127:64];
            fb_lo_q     <= keystream[63:0];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.out_hi    = out_hi_q;
  assign rsp_o.out_lo    = out_lo_q;
  assign rsp_o.out_bytes = out_bytes_q;

endmodule

/* rtl/sm4ofb_chk.sv */
// ----------------------------------------------------------------------------
// sm4ofb_chk
// Port-level checks for the SM4 OFB cipher, bound to the top level.
// ----------------------------------------------------------------------------
module sm4ofb_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic [1:0]  req_operation_i,
  input logic [4:0]  req_valid_bytes_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [63:0] rsp_out_hi_i,
  input logic [63:0] rsp_out_lo_i,
  input logic [4:0]  rsp_out_bytes_i
);
  import sm4ofb_pkg::*;

  logic data_fire;
  assign data_fire = req_valid_i && req_ready_i && (op_e'(req_operation_i) == OP_DATA)
                     && (req_valid_bytes_i != '0);

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_out_hi_i)
      && $stable(rsp_out_lo_i) && $stable(rsp_out_bytes_i))
    else $error("result changed while stalled");

  a_bytes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_out_bytes_i != '0 && rsp_out_bytes_i <= 5'(BLOCK_BYTES))
    else $error("out_bytes out of range");

  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_out_bytes_i <= 5'd8 |-> rsp_out_lo_i == '0)
    else $error("bytes beyond count not zero");

  // The round loop keeps the request side closed.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_fire |=> !req_ready_i ##1 !req_ready_i)
    else $error("request taken during rounds");

endmodule

bind sm4_ofb_stream_cipher_top sm4ofb_chk u_sm4ofb_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .req_operation_i   (req_i.operation),
  .req_valid_bytes_i (req_i.valid_bytes),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_out_hi_i      (rsp_o.out_hi),
  .rsp_out_lo_i      (rsp_o.out_lo),
  .rsp_out_bytes_i   (rsp_o.out_bytes)
);
